### rtl/dfhs_pkg.sv
package dfhs_pkg;

  localparam int KEY_W = 32;
  localparam int EPOCH_W = 8;
  localparam int DEF_SET_CAPACITY = 256;
  localparam logic [KEY_W-1:0] HASH_MULT = 32'h9E37_79B1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_MOD,
    S_REM,
    S_FIX,
    S_READ,
    S_CMP
  } state_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [KEY_W-1:0]   key;
  } entry_t;

endpackage

### rtl/duplicate_filter_hash_set.sv
// Lookup: a value whose home slot settles it passes S_HASH, S_READ and S_CMP before its result
// strobe; each further linear probe adds one memory read (S_READ) and one compare (S_CMP).
// A capacity that is not a power of two adds the reciprocal remainder steps S_MOD, S_REM and
// S_FIX per item. Busy until the lookup ends; no new item is taken before. Receiver cannot stall.
// Reset: synchronous, active low; busy while the SET_CAPACITY slots of the memory are swept,
// and the same sweep follows every 255th last item when the epoch mark wraps.
module duplicate_filter_hash_set #(
  parameter int SET_CAPACITY = dfhs_pkg::DEF_SET_CAPACITY
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_value,
  input  logic               in_last_item,
  output logic               out_valid,
  output logic signed [31:0] out_kept_value,
  output logic               out_table_full,
  output logic               out_end_of_array
);

  localparam int IW = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
  localparam int CW = $clog2(SET_CAPACITY + 1);
  localparam int RS = 31 + IW;
  localparam bit IS_POW2 = ((SET_CAPACITY & (SET_CAPACITY - 1)) == 0);
  localparam logic [IW-1:0] LAST_IDX = IW'(SET_CAPACITY - 1);
  localparam logic [CW-1:0] CAP_C = CW'(SET_CAPACITY);
  localparam logic [dfhs_pkg::KEY_W-1:0] CAP_K = dfhs_pkg::KEY_W'(SET_CAPACITY);
  localparam logic [dfhs_pkg::KEY_W-1:0] RECIP =
    dfhs_pkg::KEY_W'((64'd1 << RS) / SET_CAPACITY);

  dfhs_pkg::state_t state_r, state_nxt;
  dfhs_pkg::entry_t mem [SET_CAPACITY];
  dfhs_pkg::entry_t rd_r;
  dfhs_pkg::entry_t mem_wdata;
  logic             mem_we;

  logic [dfhs_pkg::KEY_W-1:0]   key_r, key_nxt;
  logic [dfhs_pkg::KEY_W-1:0]   prod_r, prod_nxt;
  logic [dfhs_pkg::KEY_W-1:0]   h_r, h_nxt;
  logic [dfhs_pkg::KEY_W-1:0]   quot_r, quot_nxt;
  logic [dfhs_pkg::KEY_W-1:0]   hash;
  logic [dfhs_pkg::KEY_W-1:0]   mul_a, mul_b;
  logic [2*dfhs_pkg::KEY_W-1:0] mul_p;
  logic [dfhs_pkg::KEY_W-1:0]   rem;
  logic                         last_r, last_nxt;
  logic [IW-1:0]                idx_r, idx_nxt;
  logic [IW-1:0]                probe_r, probe_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [dfhs_pkg::EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         full_r, full_nxt;
  logic                         eoa_r, eoa_nxt;

  logic slot_free, key_hit, probe_end, cmp_done, epoch_wrap;

  assign hash       = prod_r ^ (prod_r >> 16);
  assign slot_free  = rd_r.epoch != epoch_r;
  assign key_hit    = !slot_free && (rd_r.key == key_r);
  assign probe_end  = probe_r == LAST_IDX;
  assign cmp_done   = slot_free || key_hit || probe_end;
  assign epoch_wrap = epoch_r == '1;

  assign mul_p = (2*dfhs_pkg::KEY_W)'(mul_a) * (2*dfhs_pkg::KEY_W)'(mul_b);

  assign busy             = state_r != dfhs_pkg::S_IDLE;
  assign out_valid        = out_valid_r;
  assign out_kept_value   = key_r;
  assign out_table_full   = full_r;
  assign out_end_of_array = eoa_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx_r] <= mem_wdata;
    end
    rd_r <= mem[idx_r];
  end

  always_comb begin
    mul_a = $unsigned(in_value);
    mul_b = dfhs_pkg::HASH_MULT;
    case (state_r)
      dfhs_pkg::S_MOD: begin
        mul_a = h_r;
        mul_b = RECIP;
      end
      dfhs_pkg::S_REM: begin
        mul_a = quot_r;
        mul_b = CAP_K;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dfhs_pkg::S_CLEAR: if (idx_r == LAST_IDX) state_nxt = dfhs_pkg::S_IDLE;
      dfhs_pkg::S_IDLE:  if (start) state_nxt = dfhs_pkg::S_HASH;
      dfhs_pkg::S_HASH:  state_nxt = IS_POW2 ? dfhs_pkg::S_READ : dfhs_pkg::S_MOD;
      dfhs_pkg::S_MOD:   state_nxt = dfhs_pkg::S_REM;
      dfhs_pkg::S_REM:   state_nxt = dfhs_pkg::S_FIX;
      dfhs_pkg::S_FIX:   state_nxt = dfhs_pkg::S_READ;
      dfhs_pkg::S_READ:  state_nxt = dfhs_pkg::S_CMP;
      dfhs_pkg::S_CMP: begin
        if (!cmp_done) begin
          state_nxt = dfhs_pkg::S_READ;
        end else if (last_r && epoch_wrap) begin
          state_nxt = dfhs_pkg::S_CLEAR;
        end else begin
          state_nxt = dfhs_pkg::S_IDLE;
        end
      end
      default: state_nxt = dfhs_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    key_nxt       = key_r;
    prod_nxt      = prod_r;
    h_nxt         = h_r;
    quot_nxt      = quot_r;
    last_nxt      = last_r;
    idx_nxt       = idx_r;
    probe_nxt     = probe_r;
    count_nxt     = count_r;
    epoch_nxt     = epoch_r;
    out_valid_nxt = 1'b0;
    full_nxt      = full_r;
    eoa_nxt       = eoa_r;
    mem_we        = 1'b0;
    mem_wdata     = '{epoch: epoch_r, key: key_r};
    rem           = '0;
    case (state_r)
      dfhs_pkg::S_CLEAR: begin
        mem_we          = 1'b1;
        mem_wdata.epoch = '0;
        idx_nxt         = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
      end
      dfhs_pkg::S_IDLE: begin
        if (start) begin
          key_nxt   = in_value;
          last_nxt  = in_last_item;
          prod_nxt  = mul_p[dfhs_pkg::KEY_W-1:0];
          probe_nxt = '0;
        end
      end
      dfhs_pkg::S_HASH: begin
        if (IS_POW2) begin
          idx_nxt = hash[IW-1:0];
        end else begin
          h_nxt = hash;
        end
      end
      dfhs_pkg::S_MOD: begin
        quot_nxt = dfhs_pkg::KEY_W'(mul_p >> RS);
      end
      dfhs_pkg::S_REM: begin
        prod_nxt = mul_p[dfhs_pkg::KEY_W-1:0];
      end
      dfhs_pkg::S_FIX: begin
        rem = h_r - prod_r;
        if (rem >= CAP_K) begin
          rem = rem - CAP_K;
        end
        idx_nxt = rem[IW-1:0];
      end
      dfhs_pkg::S_READ: begin
      end
      dfhs_pkg::S_CMP: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          eoa_nxt       = last_r;
          if (count_r < CAP_C) begin
            mem_we    = 1'b1;
            count_nxt = count_r + 1'b1;
            full_nxt  = 1'b0;
          end else begin
            full_nxt  = 1'b1;
          end
        end else if (!key_hit && probe_end) begin
          out_valid_nxt = 1'b1;
          eoa_nxt       = last_r;
          full_nxt      = 1'b1;
        end else if (!key_hit) begin
          probe_nxt = probe_r + 1'b1;
          idx_nxt   = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
        end
        if (cmp_done && last_r) begin
          count_nxt = '0;
          if (epoch_wrap) begin
            epoch_nxt = dfhs_pkg::EPOCH_W'(1);
            idx_nxt   = '0;
          end else begin
            epoch_nxt = epoch_r + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dfhs_pkg::S_CLEAR;
      idx_r       <= '0;
      count_r     <= '0;
      epoch_r     <= dfhs_pkg::EPOCH_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
      epoch_r     <= epoch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    prod_r  <= prod_nxt;
    h_r     <= h_nxt;
    quot_r  <= quot_nxt;
    last_r  <= last_nxt;
    probe_r <= probe_nxt;
    full_r  <= full_nxt;
    eoa_r   <= eoa_nxt;
  end

`ifndef SYNTHESIS
  a_out_after_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == dfhs_pkg::S_CMP))
    else $error("result strobe without a finished lookup");

  a_start_to_hash: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == dfhs_pkg::S_HASH))
    else $error("accepted transfer did not start hashing");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("stored count above capacity");

  a_epoch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    epoch_r != '0)
    else $error("live epoch equals the cleared mark");
`endif

endmodule

### verif/tb_duplicate_filter_hash_set.sv
`timescale 1ns / 1ps

module tb_duplicate_filter_hash_set;

  localparam int CAPACITY = dfhs_pkg::DEF_SET_CAPACITY;
  localparam int TOTAL_ITEMS = 1900;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 1000;

  typedef struct {
    logic [31:0] value;
    logic        last;
    bit          drain;
    bit          quiet;
  } item_t;

  typedef struct {
    logic [31:0] kept;
    logic        full;
    logic        eoa;
  } result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] in_value = '0;
  logic               in_last_item = 1'b0;
  logic               out_valid;
  logic signed [31:0] out_kept_value;
  logic               out_table_full;
  logic               out_end_of_array;

  item_t   pending_items[$];
  item_t   cur_item;
  result_t expected_kept[$];
  result_t head_result;
  bit      seen_values[logic [31:0]];
  int      stored_count = 0;
  int      items_built = 0;
  int      items_sent = 0;
  int      arrays_sent = 0;
  int      kept_count = 0;
  int      full_count = 0;
  int      dropped_count = 0;
  int      err_count = 0;
  int      idle_cycles = 0;

  duplicate_filter_hash_set #(
    .SET_CAPACITY(CAPACITY)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_value        (in_value),
    .in_last_item    (in_last_item),
    .out_valid       (out_valid),
    .out_kept_value  (out_kept_value),
    .out_table_full  (out_table_full),
    .out_end_of_array(out_end_of_array)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic add_item(input logic [31:0] value, input logic last, input bit drain);
    item_t it;
    it.value = value;
    it.last  = last;
    it.drain = drain;
    it.quiet = (items_built >= 700 && items_built < 1000);
    pending_items.insert(pending_items.size(), it);
    items_built++;
  endtask

  task automatic filter_value(input logic [31:0] value, input logic last);
    result_t r;
    if (!seen_values.exists(value)) begin
      r.kept = value;
      r.full = (stored_count >= CAPACITY);
      r.eoa  = last;
      if (!r.full) begin
        seen_values[value] = 1'b1;
        stored_count++;
      end else begin
        full_count++;
      end
      expected_kept.insert(expected_kept.size(), r);
      kept_count++;
    end else begin
      dropped_count++;
    end
    if (last) begin
      seen_values.delete();
      stored_count = 0;
      arrays_sent++;
    end
  endtask

  // driver: hold while busy, pause for drain marks, idle at random outside quiet items
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        filter_value(cur_item.value, cur_item.last);
        items_sent++;
      end
      if (!(start && busy)) begin
        if (pending_items.size() == 0) begin
          start <= 1'b0;
        end else if (pending_items[0].drain && (expected_kept.size() != 0 || busy)) begin
          start <= 1'b0;
        end else if (!pending_items[0].quiet && $urandom_range(99) < 27) begin
          start <= 1'b0;
        end else begin
          cur_item = pending_items.pop_front();
          start        <= 1'b1;
          in_value     <= cur_item.value;
          in_last_item <= cur_item.last;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (expected_kept.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %h", out_kept_value));
      end else begin
        head_result = expected_kept.pop_front();
        if (out_kept_value !== head_result.kept)
          report_mismatch($sformatf("kept_value %h, want %h", out_kept_value,
                                    head_result.kept));
        if (out_table_full !== head_result.full)
          report_mismatch($sformatf("table_full %b, want %b for %h", out_table_full,
                                    head_result.full, head_result.kept));
        if (out_end_of_array !== head_result.eoa)
          report_mismatch($sformatf("end_of_array %b, want %b for %h", out_end_of_array,
                                    head_result.eoa, head_result.kept));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("duplicate_filter_hash_set test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          len;
    int          pick;
    logic [31:0] v;
    logic [31:0] used[$];

    add_item(32'h0000_0000, 1'b0, 1'b0);
    add_item(32'hFFFF_FFFF, 1'b0, 1'b0);
    add_item(32'h7FFF_FFFF, 1'b0, 1'b0);
    add_item(32'h8000_0000, 1'b0, 1'b0);
    add_item(32'h0000_0000, 1'b0, 1'b0);
    add_item(32'h8000_0000, 1'b0, 1'b0);
    add_item(32'h0000_0001, 1'b1, 1'b0);
    add_item(32'h0000_0005, 1'b0, 1'b0);
    add_item(32'h0000_0005, 1'b1, 1'b0);
    add_item(32'h7FFF_FFFF, 1'b1, 1'b1);
    add_item(32'h5555_5555, 1'b0, 1'b0);
    add_item(32'hAAAA_AAAA, 1'b0, 1'b0);
    add_item(32'h5555_5555, 1'b0, 1'b0);
    add_item(32'hAAAA_AAAA, 1'b1, 1'b0);

    for (int a = 0; items_built < TOTAL_ITEMS; a++) begin
      len = (a == 40 || a == 200) ? 320 : $urandom_range(1, 6);
      used.delete();
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(99);
        if (used.size() != 0 && pick < ((len > 6) ? 10 : 35))
          v = used[$urandom_range(used.size() - 1)];
        else if (pick > 90)
          v = pick[0] ? ~32'($urandom_range(15)) : 32'($urandom_range(15));
        else
          v = $urandom;
        used.insert(used.size(), v);
        add_item(v, i == len - 1, i == 0 && a % 90 == 0);
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (items_sent != items_built) @(posedge clk);
    while (expected_kept.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_kept.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_kept.size()));

    $display("%0d values in %0d arrays: %0d kept, %0d dropped as repeats",
             items_sent, arrays_sent, kept_count, dropped_count);
    $display("%0d values passed on with the set at capacity", full_count);
    if (err_count == 0) begin
      $display("duplicate_filter_hash_set test passed");
    end else begin
      $display("duplicate_filter_hash_set test failed");
    end
    $finish;
  end

endmodule
